### hw/rtl/atda_pkg.sv
// Shared constants for the along-track distance accumulator.
`default_nettype none
package atda_pkg;

	// Field widths
	localparam int LAT_W  = 21;
	localparam int LON_W  = 23;
	localparam int LONM_W = 24;   // longitude after optional +360 deg mapping
	localparam int PLON_W = 25;   // previous longitude after dateline fix
	localparam int DIFF_W = 26;
	localparam int X_W    = 33;
	localparam int DLON_W = 24;
	localparam int DLAT_W = 21;
	localparam int ABS_W  = 22;   // |lat + prev lat|
	localparam int COS_W  = 17;
	localparam int EX_W   = 31;
	localparam int EY_W   = 27;
	localparam int SQ_W   = 62;
	localparam int S_W    = 31;
	localparam int TOT_W  = 32;
	localparam int MUL_W  = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W  = 23;
	localparam int DEN_W  = 21;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_X_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT_KM     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LON    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_VALID = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_LAT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_LON   = 3'd5;

	// Output modes
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_LAT  = 2'd1;
	localparam logic [1:0] MODE_LON  = 2'd2;
	localparam logic [1:0] MODE_DIST = 2'd3;

	// Angles in 1e-4 degree
	localparam logic [DEN_W-1:0] DIV_DEN  = 21'd1800000;
	localparam logic [DEN_W-1:0] DIV_HALF = 21'd900000;
	localparam logic [DIFF_W-1:0] DEG179  = 26'd1790000;
	localparam logic [DIFF_W-1:0] DEG180  = 26'd1800000;
	localparam logic [PLON_W-1:0] DEG360  = 25'd3600000;

	// Step scale factors: 6 milli-nm per Q6 unit, 11.119492 milli-km per Q6 unit in Q16
	localparam logic [MUL_W-1:0] NM_FACTOR = 32'd6;
	localparam logic [MUL_W-1:0] KM_FACTOR = 32'd728727;

	// Cosine series magnitudes in Q28, evaluated as nested multiply-subtract
	localparam logic [MUL_W-1:0] COS_C0 = 32'd268435456;
	localparam logic [MUL_W-1:0] COS_C1 = 32'd331168970;
	localparam logic [MUL_W-1:0] COS_C2 = 32'd68093892;
	localparam logic [MUL_W-1:0] COS_C3 = 32'd5600498;
	localparam logic [MUL_W-1:0] COS_C4 = 32'd246762;
	localparam logic [MUL_W-1:0] COS_C5 = 32'd6765;
	localparam logic [MUL_W-1:0] COS_C6 = 32'd126;
	localparam logic [COS_W-1:0] COS_ONE = 17'h10000;

endpackage
`default_nettype wire

### hw/rtl/along_track_distance_accumulator.sv
// Top level: along-track distance accumulator with its sequencer and state.
`default_nettype none
// Takes one station position per item and returns one result item: the
// latitude, the (optionally 0..360 mapped) longitude, or the running along-
// track distance in milli-nm or milli-km, plus a one-time sign-flip warning
// and a saturation flag. Latitude, longitude and unused modes go straight to
// the output register. A distance item runs through a bit-serial divider for
// the cosine index, a cosine series on the shared bit-serial multiplier (seven
// passes), four more multiplier passes and a 31-bit square root; the serial
// multiplier dominates. The first station without a start position skips the
// arithmetic. One item is in work at a time; a finished result waits in the
// output register while the next item is taken.
module along_track_distance_accumulator import atda_pkg::*; #(
	parameter int COS_TABLE_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [47:0]          s_tdata,    // latitude[20:0], longitude[43:21]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,    // x_value[32:0], sign_flip_warning[33],
	                                         // distance_saturated[34]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);
	localparam int IDX_W = COS_TABLE_BITS + 1;
	localparam int N_W   = ABS_W + COS_TABLE_BITS + 1;
	localparam int Q_W   = COS_TABLE_BITS + 2;
	localparam logic [IDX_W-1:0] IDX_MAX = {1'b1, {COS_TABLE_BITS{1'b0}}};

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_PREP1 = 5'd1;
	localparam logic [4:0] S_PREP2 = 5'd2;
	localparam logic [4:0] S_DIVGO = 5'd3;
	localparam logic [4:0] S_DIVW  = 5'd4;
	localparam logic [4:0] S_COS   = 5'd5;
	localparam logic [4:0] S_MXGO  = 5'd6;
	localparam logic [4:0] S_MXW   = 5'd7;
	localparam logic [4:0] S_MEXGO = 5'd8;
	localparam logic [4:0] S_MEXW  = 5'd9;
	localparam logic [4:0] S_MEYGO = 5'd10;
	localparam logic [4:0] S_MEYW  = 5'd11;
	localparam logic [4:0] S_SQGO  = 5'd12;
	localparam logic [4:0] S_SQW   = 5'd13;
	localparam logic [4:0] S_STGO  = 5'd14;
	localparam logic [4:0] S_STW   = 5'd15;
	localparam logic [4:0] S_ACC   = 5'd16;
	localparam logic [4:0] S_DONE  = 5'd17;
	localparam logic [4:0] S_CUGO  = 5'd18;
	localparam logic [4:0] S_CUW   = 5'd19;
	localparam logic [4:0] S_CRGO  = 5'd20;
	localparam logic [4:0] S_CRW   = 5'd21;

	// configuration
	logic [1:0]        x_mode_q;
	logic              unit_km_q;
	logic              wrap_lon_q;
	logic              start_valid_q;
	logic [LAT_W-1:0]  start_lat_q;
	logic [LON_W-1:0]  start_lon_q;

	// persistent state
	logic [4:0]        state_q;
	logic [LAT_W-1:0]  prev_lat_q;
	logic [LONM_W-1:0] prev_lon_q;
	logic              have_prev_q;
	logic              warned_q;
	logic [TOT_W-1:0]  total_q;

	// per-item working registers
	logic [1:0]        mode_q;
	logic [LAT_W-1:0]  lat_q;
	logic [LONM_W-1:0] lon_q;
	logic              known_q;
	logic [LAT_W-1:0]  plat_q;
	logic [PLON_W-1:0] plon_q;
	logic [DLON_W-1:0] dlon_q;
	logic [DLAT_W-1:0] dlat_q;
	logic [ABS_W-1:0]  a_q;
	logic              warn_q;
	logic [IDX_W-1:0]  idx_q;
	logic [MUL_W-1:0]  u_q;
	logic [MUL_W-1:0]  r_q;
	logic [2:0]        k_q;
	logic [COS_W-1:0]  c_q;
	logic [EX_W-1:0]   ex_q;
	logic [SQ_W-1:0]   sq_q;
	logic [S_W-1:0]    s_q;
	logic [TOT_W-1:0]  step_q;

	// output register
	logic              m_valid_q;
	logic [X_W-1:0]    out_x_q;
	logic              out_warn_q;
	logic              out_sat_q;

	logic              s_acc;
	logic [LAT_W-1:0]  in_lat;
	logic [LON_W-1:0]  in_lon;
	logic [LONM_W-1:0] in_lon_ext;
	logic [LONM_W-1:0] in_lon_map;

	// input decode and optional mapping of negative longitudes
	assign s_tready   = (state_q == S_IDLE);
	assign s_acc      = s_tvalid && s_tready;
	assign in_lat     = s_tdata[20:0];
	assign in_lon     = s_tdata[43:21];
	assign in_lon_ext = {in_lon[LON_W-1], in_lon};
	assign in_lon_map = (wrap_lon_q && in_lon[LON_W-1]) ?
		in_lon_ext + DEG360[LONM_W-1:0] : in_lon_ext;

	// previous position and dateline correction
	logic [LAT_W-1:0]  plat_c;
	logic [LONM_W-1:0] plon_c;
	logic              known_c;
	logic [PLON_W-1:0] d1;
	logic [PLON_W-1:0] absd1;
	logic              lon_neg;
	logic              lon_pos;
	logic              opp1;
	logic [PLON_W-1:0] plon_adj;

	assign known_c = have_prev_q || start_valid_q;
	assign plat_c  = have_prev_q ? prev_lat_q : (start_valid_q ? start_lat_q : '0);
	assign plon_c  = have_prev_q ? prev_lon_q :
		(start_valid_q ? {start_lon_q[LON_W-1], start_lon_q} : '0);
	assign lon_neg = lon_q[LONM_W-1];
	assign lon_pos = !lon_q[LONM_W-1] && (lon_q != '0);
	assign opp1    = (lon_neg && !plon_c[LONM_W-1] && (plon_c != '0)) ||
		(lon_pos && plon_c[LONM_W-1]);
	assign d1      = {lon_q[LONM_W-1], lon_q} - {plon_c[LONM_W-1], plon_c};
	assign absd1   = d1[PLON_W-1] ? -d1 : d1;
	assign plon_adj = (known_c && opp1 && ({1'b0, absd1} > DEG180)) ?
		(lon_neg ? {plon_c[LONM_W-1], plon_c} - DEG360 :
			{plon_c[LONM_W-1], plon_c} + DEG360) :
		{plon_c[LONM_W-1], plon_c};

	// deltas, cosine argument and warning test
	logic [DIFF_W-1:0] d2;
	logic [DIFF_W-1:0] absd2;
	logic              opp2;
	logic [ABS_W-1:0]  dl;
	logic [ABS_W-1:0]  absdl;
	logic [ABS_W-1:0]  sl;
	logic [ABS_W-1:0]  abssl;
	logic              warn_c;

	assign d2     = {{2{lon_q[LONM_W-1]}}, lon_q} - {plon_q[PLON_W-1], plon_q};
	assign absd2  = d2[DIFF_W-1] ? -d2 : d2;
	assign opp2   = (lon_neg && !plon_q[PLON_W-1] && (plon_q != '0)) ||
		(lon_pos && plon_q[PLON_W-1]);
	assign dl     = {lat_q[LAT_W-1], lat_q} - {plat_q[LAT_W-1], plat_q};
	assign absdl  = dl[ABS_W-1] ? -dl : dl;
	assign sl     = {lat_q[LAT_W-1], lat_q} + {plat_q[LAT_W-1], plat_q};
	assign abssl  = sl[ABS_W-1] ? -sl : sl;
	assign warn_c = opp2 && (absd2 > DEG179) && !warned_q;

	// cosine index divider
	logic           div_done;
	logic [Q_W-1:0] div_q;
	logic           div_ovf;
	logic [N_W-1:0] div_num;

	assign div_num = {1'b0, a_q, {COS_TABLE_BITS{1'b0}}} + N_W'(DIV_HALF);

	atda_sdiv #(.NW(N_W), .QW(Q_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_DIVGO),
		.num    (div_num),
		.done   (div_done),
		.quo    (div_q),
		.ovf    (div_ovf)
	);

	// shared serial multiplier, operands chosen by sequencer state
	logic               mul_start;
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic               mul_done;
	logic [2*MUL_W-1:0] mul_p;
	logic [2*MUL_W-1:0] ex_rnd;
	logic [2*MUL_W-1:0] st_rnd;

	// cosine series terms
	logic [MUL_W-1:0]   t_c;
	logic [2*MUL_W-1:0] cr_rnd;
	logic [MUL_W-1:0]   p_c;
	logic [MUL_W-1:0]   coef_k;
	logic [MUL_W-1:0]   c_rnd;

	assign t_c    = MUL_W'(idx_q) << (28 - COS_TABLE_BITS);
	assign cr_rnd = mul_p + (64'd1 << 27);
	assign p_c    = cr_rnd[MUL_W+27:28];
	assign c_rnd  = r_q + 32'd2048;

	always_comb begin
		case (k_q)
			3'd0:    coef_k = COS_C0;
			3'd1:    coef_k = COS_C1;
			3'd2:    coef_k = COS_C2;
			3'd3:    coef_k = COS_C3;
			3'd4:    coef_k = COS_C4;
			3'd5:    coef_k = COS_C5;
			default: coef_k = COS_C6;
		endcase
	end

	assign mul_start = (state_q == S_MXGO) || (state_q == S_MEXGO) ||
		(state_q == S_MEYGO) || (state_q == S_STGO) ||
		(state_q == S_CUGO) || (state_q == S_CRGO);

	always_comb begin
		case (state_q)
			S_CUGO: begin
				mul_a = t_c;
				mul_b = t_c;
			end
			S_CRGO: begin
				mul_a = u_q;
				mul_b = r_q;
			end
			S_MXGO: begin
				mul_a = MUL_W'(dlon_q);
				mul_b = MUL_W'(c_q);
			end
			S_MEXGO: begin
				mul_a = MUL_W'(ex_q);
				mul_b = MUL_W'(ex_q);
			end
			S_MEYGO: begin
				mul_a = MUL_W'({dlat_q, 6'b0});
				mul_b = MUL_W'({dlat_q, 6'b0});
			end
			S_STGO: begin
				mul_a = MUL_W'(s_q);
				mul_b = unit_km_q ? KM_FACTOR : NM_FACTOR;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	atda_smul #(.W(MUL_W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign ex_rnd = mul_p + 64'd512;
	assign st_rnd = unit_km_q ? mul_p + (64'd1 << 21) : mul_p + 64'd32;

	// square root of the summed squares
	logic           sq_done;
	logic [S_W-1:0] sq_root;

	atda_isqrt #(.RW(S_W)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_SQGO),
		.v      (sq_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// saturating accumulate
	logic [TOT_W:0] tsum;
	assign tsum = {1'b0, total_q} + {1'b0, step_q};

	// result value
	logic [X_W-1:0] x_c;
	always_comb begin
		case (mode_q)
			MODE_LAT:  x_c = {{(X_W - LAT_W){lat_q[LAT_W-1]}}, lat_q};
			MODE_LON:  x_c = {{(X_W - LONM_W){lon_q[LONM_W-1]}}, lon_q};
			MODE_DIST: x_c = {1'b0, total_q};
			default:   x_c = '1;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_mode_q      <= MODE_DIST;
			unit_km_q     <= 1'b0;
			wrap_lon_q    <= 1'b0;
			start_valid_q <= 1'b0;
			start_lat_q   <= '0;
			start_lon_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_X_MODE:      x_mode_q      <= cfg_data[1:0];
				CFG_UNIT_KM:     unit_km_q     <= cfg_data[0];
				CFG_WRAP_LON:    wrap_lon_q    <= cfg_data[0];
				CFG_START_VALID: start_valid_q <= cfg_data[0];
				CFG_START_LAT:   start_lat_q   <= cfg_data[LAT_W-1:0];
				CFG_START_LON:   start_lon_q   <= cfg_data[LON_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and track state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_lat_q  <= '0;
			prev_lon_q  <= '0;
			have_prev_q <= 1'b0;
			warned_q    <= 1'b0;
			total_q     <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && (!m_valid_q || m_tready))
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (s_acc)
					state_q <= (x_mode_q == MODE_DIST) ? S_PREP1 : S_DONE;
				S_PREP1: state_q <= S_PREP2;
				S_PREP2: state_q <= known_q ? S_DIVGO : S_ACC;
				S_DIVGO: state_q <= S_DIVW;
				S_DIVW:  if (div_done) state_q <= S_CUGO;
				S_CUGO:  state_q <= S_CUW;
				S_CUW:   if (mul_done) state_q <= S_CRGO;
				S_CRGO:  state_q <= S_CRW;
				S_CRW:   if (mul_done) state_q <= (k_q == 3'd0) ? S_COS : S_CRGO;
				S_COS:   state_q <= S_MXGO;
				S_MXGO:  state_q <= S_MXW;
				S_MXW:   if (mul_done) state_q <= S_MEXGO;
				S_MEXGO: state_q <= S_MEXW;
				S_MEXW:  if (mul_done) state_q <= S_MEYGO;
				S_MEYGO: state_q <= S_MEYW;
				S_MEYW:  if (mul_done) state_q <= S_SQGO;
				S_SQGO:  state_q <= S_SQW;
				S_SQW:   if (sq_done) state_q <= S_STGO;
				S_STGO:  state_q <= S_STW;
				S_STW:   if (mul_done) state_q <= S_ACC;
				S_ACC: begin
					total_q     <= tsum[TOT_W] ? '1 : tsum[TOT_W-1:0];
					prev_lat_q  <= lat_q;
					prev_lon_q  <= lon_q;
					have_prev_q <= 1'b1;
					if (warn_q)
						warned_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: if (!m_valid_q || m_tready)
					state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (s_acc) begin
				mode_q <= x_mode_q;
				lat_q  <= in_lat;
				lon_q  <= in_lon_map;
				warn_q <= 1'b0;
			end
			S_PREP1: begin
				known_q <= known_c;
				plat_q  <= plat_c;
				plon_q  <= plon_adj;
			end
			S_PREP2: begin
				dlon_q <= absd2[DLON_W-1:0];
				dlat_q <= absdl[DLAT_W-1:0];
				a_q    <= abssl;
				warn_q <= warn_c;
				step_q <= '0;
			end
			S_DIVW: if (div_done)
				idx_q <= (div_ovf || (div_q > Q_W'(IDX_MAX))) ? IDX_MAX : div_q[IDX_W-1:0];
			// u = t^2 in Q28, series starts from the highest coefficient
			S_CUW: if (mul_done) begin
				u_q <= p_c;
				r_q <= COS_C6;
				k_q <= 3'd5;
			end
			// r = max(0, Ck - u*r)
			S_CRW: if (mul_done) begin
				r_q <= (p_c >= coef_k) ? '0 : coef_k - p_c;
				k_q <= k_q - 1'b1;
			end
			S_COS:  c_q <= (c_rnd[MUL_W-1:12] > (MUL_W-12)'(COS_ONE)) ?
				COS_ONE : c_rnd[COS_W+11:12];
			S_MXW:  if (mul_done) ex_q <= ex_rnd[EX_W+9:10];
			S_MEXW: if (mul_done) sq_q <= mul_p[SQ_W-1:0];
			S_MEYW: if (mul_done) sq_q <= sq_q + mul_p[SQ_W-1:0];
			S_SQW:  if (sq_done) s_q <= sq_root;
			S_STW:  if (mul_done)
				step_q <= unit_km_q ? st_rnd[TOT_W+21:22] : st_rnd[TOT_W+5:6];
			S_DONE: if (!m_valid_q || m_tready) begin
				out_x_q    <= x_c;
				out_warn_q <= (mode_q == MODE_DIST) && warn_q;
				out_sat_q  <= (total_q == '1);
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, out_sat_q, out_warn_q, out_x_q};
endmodule
`default_nettype wire

### hw/rtl/atda_smul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module atda_smul import atda_pkg::*; #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic           done,
	output logic [2*W-1:0] p
);
	localparam int CNT_W = $clog2(W);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     a_q;
	logic [W-1:0]     b_q;
	logic [2*W-1:0]   acc_q;
	logic [W:0]       sum;

	// add the multiplicand into the upper half when the low multiplier bit is set
	assign sum = {1'b0, acc_q[2*W-1:W]} + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= {sum, acc_q[W-1:1]};
			b_q   <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = acc_q;
endmodule
`default_nettype wire

### hw/rtl/atda_sdiv.sv
// Restoring divider by the 180 deg constant, one quotient bit per cycle.
`default_nettype none
module atda_sdiv import atda_pkg::*; #(
	parameter int NW = 33,
	parameter int QW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	output logic          done,
	output logic [QW-1:0] quo,
	output logic          ovf
);
	localparam int CNT_W = $clog2(NW);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    n_q;
	logic [DEN_W-1:0] rem_q;
	logic [QW-1:0]    q_q;
	logic             ovf_q;
	logic [DEN_W:0]   t;
	logic [DEN_W:0]   t_sub;
	logic             ge;

	assign t     = {rem_q, n_q[NW-1]};
	assign ge    = t >= {1'b0, DIV_DEN};
	assign t_sub = t - {1'b0, DIV_DEN};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(NW - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1))
					run_q <= 1'b0;
			end
		end
	end

	// quotient bits that fall off the top only mark overflow
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (run_q) begin
			n_q   <= n_q << 1;
			rem_q <= ge ? t_sub[DEN_W-1:0] : t[DEN_W-1:0];
			q_q   <= {q_q[QW-2:0], ge};
			ovf_q <= ovf_q | q_q[QW-1];
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign ovf  = ovf_q;
endmodule
`default_nettype wire

### hw/rtl/atda_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none
module atda_isqrt import atda_pkg::*; #(
	parameter int RW = 31
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] v,
	output logic            done,
	output logic [RW-1:0]   root
);
	localparam int CNT_W = $clog2(RW);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2*RW-1:0]  v_q;
	logic [RW+1:0]    rem_q;
	logic [RW-1:0]    root_q;
	logic [RW+3:0]    t;
	logic [RW+3:0]    trial;
	logic             ge;
	logic [RW+3:0]    t_sub;

	// bring down two radicand bits, try root*4+1
	assign t     = {rem_q, v_q[2*RW-1:2*RW-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = t >= trial;
	assign t_sub = t - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(RW - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(RW - 1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= v;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			v_q    <= v_q << 2;
			rem_q  <= ge ? t_sub[RW+1:0] : t[RW+1:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

### hw/rtl/atda_checker.sv
// Port-level checker for the along-track distance accumulator, with its bind.
`default_nettype none
module atda_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);
	logic sat_seen_q;
	logic warn_seen_q;

	// remember flags of items already delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_seen_q  <= 1'b0;
			warn_seen_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			if (m_tdata[34])
				sat_seen_q <= 1'b1;
			if (m_tdata[33])
				warn_seen_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && sat_seen_q |-> m_tdata[34])
		else $error("distance saturation cleared");

	a_warn_once: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && warn_seen_q |-> !m_tdata[33])
		else $error("sign-flip warning given twice");
endmodule

bind along_track_distance_accumulator atda_port_checker u_atda_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
